[src/assert_macros.svh]
// Assertion helpers shared by the RTL. Both forms are checked at the rising
// edge of clk and are switched off while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A condition that must hold at every clock edge.
`define ASSERT_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error(msg);

// A consequent that must hold in the cycle after its antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/fkc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fkc_pkg
// Shared widths, status codes, defaults and cell control type of the
// insertion-ordered key/value cache.
// ----------------------------------------------------------------------------
package fkc_pkg;

  localparam int KEY_W          = 32;
  localparam int VALUE_W        = 32;
  localparam int STATUS_W       = 3;
  localparam int CAP_W          = 5;
  localparam int DEPTH_DEF      = 16;
  localparam int DATA_WIDTH_DEF = 32;

  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  localparam logic OP_PUT = 1'b0;
  localparam logic OP_GET = 1'b1;

  localparam logic [STATUS_W-1:0] ST_GET_HIT      = 3'd0;
  localparam logic [STATUS_W-1:0] ST_GET_MISS     = 3'd1;
  localparam logic [STATUS_W-1:0] ST_PUT_UPDATED  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_PUT_INSERTED = 3'd3;
  localparam logic [STATUS_W-1:0] ST_PUT_EVICTED  = 3'd4;

  // Per-cell control: cmp_en captures the key compare, shift_en loads the
  // entry of the neighbor in front.
  typedef struct packed {
    logic cmp_en;
    logic shift_en;
  } cell_ctrl_t;

endpackage

[src/fkc_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fkc_cell
// One entry of the cache chain: holds a key, a value and a valid flag,
// compares its key against a request and takes its front neighbor's entry.
// ----------------------------------------------------------------------------
module fkc_cell #(
  parameter int VW = 32
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  fkc_pkg::cell_ctrl_t       ctrl,
  input  logic [fkc_pkg::KEY_W-1:0] cmp_key,
  input  logic                      prev_valid,
  input  logic [fkc_pkg::KEY_W-1:0] prev_key,
  input  logic [VW-1:0]             prev_value,
  output logic                      valid,
  output logic [fkc_pkg::KEY_W-1:0] key,
  output logic [VW-1:0]             value,
  output logic                      match
);

  logic                      valid_r;
  logic                      valid_nxt;
  logic                      match_r;
  logic                      match_nxt;
  logic [fkc_pkg::KEY_W-1:0] key_r;
  logic [fkc_pkg::KEY_W-1:0] key_nxt;
  logic [VW-1:0]             value_r;
  logic [VW-1:0]             value_nxt;

  always_comb begin
    valid_nxt = valid_r;
    key_nxt   = key_r;
    value_nxt = value_r;
    match_nxt = match_r;
    if (ctrl.cmp_en) begin
      match_nxt = valid_r && (key_r == cmp_key);
    end
    if (ctrl.shift_en) begin
      valid_nxt = prev_valid;
      key_nxt   = prev_key;
      value_nxt = prev_value;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      match_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      match_r <= match_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r   <= key_nxt;
    value_r <= value_nxt;
  end

  assign valid = valid_r;
  assign key   = key_r;
  assign value = value_r;
  assign match = match_r;

endmodule

[src/fifo_keyed_cache.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fifo_keyed_cache
// Fully associative key/value cache kept in insertion order, built as a row
// of entry cells that shift toward the back.
// ----------------------------------------------------------------------------
// Usage:
//   A request (in_op, in_key, in_value) is taken when start is high and busy
//   is low. A put overwrites a present key and moves it to the front, or
//   inserts a new key at the front, dropping the oldest entry once the count
//   has reached the capacity register, clamped to 1..DEPTH. A get looks a
//   key up without reordering.
//   A request is handled by a key compare in every cell in parallel, then
//   by encoding the hit position as the cells in front of it shift by one.
//   busy is high during the shift, so no new request is taken until the last
//   one has finished. The result appears on out_status, out_read_value and
//   out_evicted_key for one cycle with out_valid, registered from the shift
//   step. The receiver cannot stall; nothing waits on it.
//   The capacity register is written over cfg_valid/cfg_ready/cfg_data and
//   is always ready. Reset empties the cache and sets the capacity to 16.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module fifo_keyed_cache #(
  parameter int DEPTH      = fkc_pkg::DEPTH_DEF,
  parameter int DATA_WIDTH = fkc_pkg::DATA_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic                         in_op,
  input  logic [fkc_pkg::KEY_W-1:0]    in_key,
  input  logic [fkc_pkg::VALUE_W-1:0]  in_value,
  output logic                         out_valid,
  output logic [fkc_pkg::STATUS_W-1:0] out_status,
  output logic [fkc_pkg::VALUE_W-1:0]  out_read_value,
  output logic [fkc_pkg::KEY_W-1:0]    out_evicted_key,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [fkc_pkg::CAP_W-1:0]    cfg_data
);

  localparam int VW = (DATA_WIDTH < fkc_pkg::VALUE_W) ? DATA_WIDTH : fkc_pkg::VALUE_W;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int EW = (CW > fkc_pkg::CAP_W) ? CW : fkc_pkg::CAP_W;

  localparam logic [EW-1:0] DEPTH_E = EW'(DEPTH);
  localparam logic [CW-1:0] LAST_POS = CW'(DEPTH - 1);

  logic                         accept;
  logic                         busy_r;
  logic                         busy_nxt;
  logic [fkc_pkg::CAP_W-1:0]    cap_r;
  logic [fkc_pkg::CAP_W-1:0]    cap_nxt;
  logic [CW-1:0]                count_r;
  logic [CW-1:0]                count_nxt;
  logic                         req_op_r;
  logic [fkc_pkg::KEY_W-1:0]    req_key_r;
  logic [VW-1:0]                req_value_r;
  logic                         out_valid_r;
  logic                         out_valid_nxt;
  logic [fkc_pkg::STATUS_W-1:0] status_r;
  logic [fkc_pkg::STATUS_W-1:0] status_nxt;
  logic [fkc_pkg::VALUE_W-1:0]  read_value_r;
  logic [fkc_pkg::VALUE_W-1:0]  read_value_nxt;
  logic [fkc_pkg::KEY_W-1:0]    evicted_key_r;
  logic [fkc_pkg::KEY_W-1:0]    evicted_key_nxt;

  fkc_pkg::cell_ctrl_t       cell_ctrl [DEPTH];
  logic                      chain_valid [DEPTH+1];
  logic [fkc_pkg::KEY_W-1:0] chain_key   [DEPTH+1];
  logic [VW-1:0]             chain_value [DEPTH+1];
  logic [DEPTH-1:0]          match;

  logic                      hit;
  logic [CW-1:0]             hit_pos;
  logic [VW-1:0]             hit_value;
  logic [fkc_pkg::KEY_W-1:0] back_key;
  logic [EW-1:0]             cap_e;
  logic [EW-1:0]             eff_cap;
  logic                      evict;
  logic [CW-1:0]             ins_pos;
  logic [CW-1:0]             shift_lim;
  logic                      do_put;

  assign accept    = start && !busy_r;
  assign cfg_ready = 1'b1;

  // Cell 0 takes the request itself; every other cell takes its front neighbor.
  assign chain_valid[0] = 1'b1;
  assign chain_key[0]   = req_key_r;
  assign chain_value[0] = req_value_r;

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    fkc_cell #(
      .VW (VW)
    ) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctrl       (cell_ctrl[g]),
      .cmp_key    (in_key),
      .prev_valid (chain_valid[g]),
      .prev_key   (chain_key[g]),
      .prev_value (chain_value[g]),
      .valid      (chain_valid[g+1]),
      .key        (chain_key[g+1]),
      .value      (chain_value[g+1]),
      .match      (match[g])
    );
  end

  // Keys are unique, so at most one match bit is set and an OR of the
  // selected indexes and values gives the hit position and data.
  always_comb begin
    hit_pos   = '0;
    hit_value = '0;
    back_key  = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (match[i]) begin
        hit_pos   = hit_pos | CW'(i);
        hit_value = hit_value | chain_value[i+1];
      end
      if (count_r == CW'(i + 1)) begin
        back_key = chain_key[i+1];
      end
    end
    hit = |match;
  end

  always_comb begin
    cap_e = EW'(cap_r);
    if (cap_e == '0) begin
      eff_cap = EW'(1);
    end else if (cap_e > DEPTH_E) begin
      eff_cap = DEPTH_E;
    end else begin
      eff_cap = cap_e;
    end
    evict   = (EW'(count_r) >= eff_cap) && (count_r != '0);
    ins_pos = evict ? (count_r - CW'(1)) : count_r;
    if (hit) begin
      shift_lim = hit_pos;
    end else if (ins_pos > LAST_POS) begin
      shift_lim = LAST_POS;
    end else begin
      shift_lim = ins_pos;
    end
    do_put = busy_r && (req_op_r == fkc_pkg::OP_PUT);
  end

  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      cell_ctrl[i].cmp_en   = accept;
      cell_ctrl[i].shift_en = do_put && (CW'(i) <= shift_lim);
    end
  end

  always_comb begin
    busy_nxt        = accept;
    cap_nxt         = cap_r;
    count_nxt       = count_r;
    out_valid_nxt   = busy_r;
    status_nxt      = fkc_pkg::ST_GET_MISS;
    read_value_nxt  = '0;
    evicted_key_nxt = '0;
    if (cfg_valid && cfg_ready) begin
      cap_nxt = cfg_data;
    end
    if (busy_r) begin
      if (req_op_r == fkc_pkg::OP_GET) begin
        if (hit) begin
          status_nxt     = fkc_pkg::ST_GET_HIT;
          read_value_nxt = fkc_pkg::VALUE_W'(hit_value);
        end
      end else if (hit) begin
        status_nxt = fkc_pkg::ST_PUT_UPDATED;
      end else begin
        status_nxt = fkc_pkg::ST_PUT_INSERTED;
        if (evict) begin
          status_nxt      = fkc_pkg::ST_PUT_EVICTED;
          evicted_key_nxt = back_key;
        end
        if (ins_pos < CW'(DEPTH)) begin
          count_nxt = ins_pos + CW'(1);
        end else begin
          count_nxt = ins_pos;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      cap_r       <= fkc_pkg::CAP_RESET;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      cap_r       <= cap_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_op_r    <= in_op;
      req_key_r   <= in_key;
      req_value_r <= in_value[VW-1:0];
    end
    status_r      <= status_nxt;
    read_value_r  <= read_value_nxt;
    evicted_key_r <= evicted_key_nxt;
  end

  assign busy            = busy_r;
  assign out_valid       = out_valid_r;
  assign out_status      = status_r;
  assign out_read_value  = read_value_r;
  assign out_evicted_key = evicted_key_r;

  `ASSERT_NEXT(a_accept_busy, accept, busy_r && !out_valid_r, "request did not enter lookup")
  `ASSERT_NEXT(a_busy_result, busy_r, out_valid_r && !busy_r, "lookup gave no result")
  `ASSERT_ALWAYS(a_count_bound, count_r <= CW'(DEPTH), "entry count above depth")
  `ASSERT_ALWAYS(a_match_unique, $onehot0(match), "key held in more than one entry")
  `ASSERT_ALWAYS(a_evict_key, !out_valid_r || status_r == fkc_pkg::ST_PUT_EVICTED || evicted_key_r == '0, "evicted key without eviction")

endmodule
